>>> rtl/adf_pkg.sv
// Shared constants for the audio decimating filter and sample FIFO.
package adf_pkg;

  localparam int STEP_W  = 24;  // tick_step and sample_period width
  localparam int PHASE_W = 25;  // phase accumulator width
  localparam int COEF_W  = 15;  // Q15 coefficient width
  localparam int CFG_W   = 24;  // config write data width
  localparam int CFG_AW  = 2;   // config register index width

  // item opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // config register indexes
  localparam logic [CFG_AW-1:0] REG_TICK_STEP     = 2'd0;
  localparam logic [CFG_AW-1:0] REG_SAMPLE_PERIOD = 2'd1;
  localparam logic [CFG_AW-1:0] REG_LP_COEF       = 2'd2;
  localparam logic [CFG_AW-1:0] REG_FADE_FACTOR   = 2'd3;

  // reset values of the config registers
  localparam logic [STEP_W-1:0] TICK_STEP_RST     = 24'd21845;
  localparam logic [STEP_W-1:0] SAMPLE_PERIOD_RST = 24'd2659701;
  localparam logic [COEF_W-1:0] LP_COEF_RST       = 15'd13107;
  localparam logic [COEF_W-1:0] FADE_FACTOR_RST   = 15'd29491;

  // Q15 rounding offset (one half)
  localparam logic [COEF_W-1:0] Q15_HALF = 15'h4000;

endpackage

>>> rtl/audio_decimate_filter_fifo_core.sv
// Audio decimator top level: config registers, sample ring, read path and output register.
// One item is taken per clock with no bubbles while in_stall is low; a result passes through
// stage 1 and then the output register. The rate is set by the phase/filter update, which
// is combinational, and the ring memory, which takes one write (tick push)
// and one registered read (pop) per cycle. The ring needs no clearing after reset.
// FIFO_DEPTH entries hold at most FIFO_DEPTH-1 samples.
module audio_decimate_filter_fifo_core
  import adf_pkg::*;
#(
  parameter int FIFO_DEPTH  = 16384,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [CFG_AW-1:0]                     wr_index,
  input  logic [CFG_W-1:0]                      wr_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            op,
  input  logic signed [SAMPLE_BITS-1:0]         raw_sample,
  input  logic                                  first_in_block,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [SAMPLE_BITS-1:0]         out_sample,
  output logic                                  underrun,
  output logic                                  pushed,
  output logic                                  dropped,
  output logic [$clog2(FIFO_DEPTH)-1:0]         fill_level
);

  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH);

  // config registers
  logic [STEP_W-1:0] tick_step;
  logic [STEP_W-1:0] sample_period;
  logic [COEF_W-1:0] lp_coef;
  logic [COEF_W-1:0] fade_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step     <= TICK_STEP_RST;
      sample_period <= SAMPLE_PERIOD_RST;
      lp_coef       <= LP_COEF_RST;
      fade_factor   <= FADE_FACTOR_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TICK_STEP:     tick_step     <= wr_data;
        REG_SAMPLE_PERIOD: sample_period <= wr_data;
        REG_LP_COEF:       lp_coef       <= wr_data[COEF_W-1:0];
        REG_FADE_FACTOR:   fade_factor   <= wr_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_valid;
  logic s1_adv;
  logic out_adv;
  logic accept;

  assign out_adv  = !out_valid || !out_stall;
  assign s1_adv   = out_adv;
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  // stage 0: phase/filter, FIFO bookkeeping, ring access
  logic                 is_tick;
  logic                 is_read;
  logic                 is_flush;
  logic                 fire;
  logic signed [SB-1:0] half_sample;

  always_comb begin
    is_tick  = 1'b0;
    is_read  = 1'b0;
    is_flush = 1'b0;
    unique case (op)
      OP_TICK:  is_tick  = 1'b1;
      OP_READ:  is_read  = 1'b1;
      OP_FLUSH: is_flush = 1'b1;
      default: ;
    endcase
  end

  adf_tick #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_tick (
    .clk           (clk),
    .rst           (rst),
    .tick          (accept && is_tick),
    .raw_sample    (raw_sample),
    .tick_step     (tick_step),
    .sample_period (sample_period),
    .lp_coef       (lp_coef),
    .fire          (fire),
    .half_sample   (half_sample)
  );

  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [AW-1:0] wr_ptr_next;
  logic [AW-1:0] rd_ptr_next;
  logic [CW-1:0] count_next;
  logic          full;
  logic          empty;
  logic          do_push;
  logic          do_drop;
  logic          do_pop;

  always_comb begin
    full    = count == CW'(FIFO_DEPTH - 1);
    empty   = count == '0;
    do_push = is_tick && fire && !full;
    do_drop = is_tick && fire && full;
    do_pop  = is_read && !empty;

    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (is_flush) begin
      wr_ptr_next = '0;
      rd_ptr_next = '0;
      count_next  = '0;
    end else if (do_push) begin
      wr_ptr_next = (wr_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      count_next  = count + 1'b1;
    end else if (do_pop) begin
      rd_ptr_next = (rd_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count_next  = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else if (accept) begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // sample ring: one write, one registered read per cycle
  logic signed [SB-1:0] ring [FIFO_DEPTH];
  logic signed [SB-1:0] ring_q;

  always_ff @(posedge clk) begin
    if (accept && do_push) begin
      ring[wr_ptr] <= half_sample;
    end
  end

  // read data holds while stage 1 waits, since no new transfer is taken then
  always_ff @(posedge clk) begin
    if (accept && do_pop) begin
      ring_q <= ring[rd_ptr];
    end
  end

  // stage 1 registers
  logic          s1_read;
  logic          s1_hit;
  logic          s1_first;
  logic          s1_pushed;
  logic          s1_dropped;
  logic [CW-1:0] s1_fill;

  // an empty stage 1 takes a transfer even while the output register is held
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv || !s1_valid) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_read    <= is_read;
      s1_hit     <= do_pop;
      s1_first   <= first_in_block;
      s1_pushed  <= do_push;
      s1_dropped <= do_drop;
      s1_fill    <= count_next;
    end
  end

  // stage 1: pop data, zero, or faded previous output
  logic signed [SB-1:0]  last_output;
  logic signed [SB+15:0] fade_prod;
  logic signed [SB+15:0] fade_rnd;
  logic signed [SB:0]    fade_q;
  logic signed [SB-1:0]  fade_sat;
  logic signed [SB-1:0]  rd_sample;

  always_comb begin
    fade_prod = last_output * $signed({1'b0, fade_factor});
    fade_rnd  = fade_prod + $signed({{(SB+1){1'b0}}, Q15_HALF});
    fade_q    = fade_rnd[SB+15:15];
    if (fade_q[SB] == fade_q[SB-1]) begin
      fade_sat = fade_q[SB-1:0];
    end else if (!fade_q[SB]) begin
      fade_sat = {1'b0, {(SB-1){1'b1}}};
    end else begin
      fade_sat = {1'b1, {(SB-1){1'b0}}};
    end

    if (!s1_read) begin
      rd_sample = '0;
    end else if (s1_hit) begin
      rd_sample = ring_q;
    end else if (s1_first) begin
      rd_sample = '0;
    end else begin
      rd_sample = fade_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_output <= '0;
    end else if (s1_adv && s1_valid && s1_read) begin
      last_output <= rd_sample;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid) begin
      out_sample <= rd_sample;
      underrun   <= s1_read && !s1_hit;
      pushed     <= s1_pushed;
      dropped    <= s1_dropped;
      fill_level <= s1_fill;
    end
  end

endmodule

>>> rtl/adf_tick.sv
// Phase accumulator, updated once per tick transfer, and one-pole low-pass filter, updated on ticks that fire.
module adf_tick
  import adf_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tick,
  input  logic signed [SAMPLE_BITS-1:0] raw_sample,
  input  logic [STEP_W-1:0]             tick_step,
  input  logic [STEP_W-1:0]             sample_period,
  input  logic [COEF_W-1:0]             lp_coef,
  output logic                          fire,
  output logic signed [SAMPLE_BITS-1:0] half_sample
);

  localparam int SB = SAMPLE_BITS;

  logic [PHASE_W-1:0]    phase_acc;
  logic [PHASE_W-1:0]    phase_acc_next;
  logic signed [SB-1:0]  filter_state;
  logic signed [SB-1:0]  y_sat;

  logic [PHASE_W:0]      p_sum;
  logic [PHASE_W:0]      p_sub;
  logic signed [SB:0]    diff;
  logic signed [SB+16:0] prod;
  logic signed [SB+16:0] prod_rnd;
  logic signed [SB+1:0]  delta;
  logic signed [SB+2:0]  y_wide;

  always_comb begin
    p_sum = {1'b0, phase_acc} + {2'b00, tick_step};
    fire  = p_sum >= {2'b00, sample_period};
    p_sub = fire ? (p_sum - {2'b00, sample_period}) : p_sum;
    // clamp at the top of the accumulator
    phase_acc_next = p_sub[PHASE_W] ? {PHASE_W{1'b1}} : p_sub[PHASE_W-1:0];
  end

  always_comb begin
    diff     = $signed({raw_sample[SB-1], raw_sample}) -
               $signed({filter_state[SB-1], filter_state});
    prod     = $signed({1'b0, lp_coef}) * diff;
    prod_rnd = prod + $signed({{(SB+2){1'b0}}, Q15_HALF});
    delta    = prod_rnd[SB+16:15];  // divide by 2^15, rounded to nearest (half up)
    y_wide   = $signed({{3{filter_state[SB-1]}}, filter_state}) +
               $signed({delta[SB+1], delta});
    if (y_wide[SB+2:SB-1] == '0 || y_wide[SB+2:SB-1] == '1) begin
      y_sat = y_wide[SB-1:0];
    end else if (!y_wide[SB+2]) begin
      y_sat = {1'b0, {(SB-1){1'b1}}};
    end else begin
      y_sat = {1'b1, {(SB-1){1'b0}}};
    end
    half_sample = {y_sat[SB-1], y_sat[SB-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc    <= '0;
      filter_state <= '0;
    end else if (tick) begin
      phase_acc <= phase_acc_next;
      if (fire) begin
        filter_state <= y_sat;
      end
    end
  end

endmodule

>>> rtl/adf_check.sv
// Port-level checker for the audio decimator, bound to the top level.
module adf_check #(
  parameter int FIFO_DEPTH  = 16384,
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] out_sample,
  input logic                          underrun,
  input logic                          pushed,
  input logic                          dropped,
  input logic [$clog2(FIFO_DEPTH)-1:0] fill_level
);

  localparam int CW = $clog2(FIFO_DEPTH);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_sample) && $stable(fill_level))
    else $error("stalled result changed");

  // an underrun means the FIFO was and stays empty
  assert property (@(posedge clk) disable iff (rst)
    out_valid && underrun |-> fill_level == '0)
    else $error("underrun with nonzero fill level");

  // a transfer never both stores and drops a sample, and never does either with an underrun
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(pushed && dropped) && !(underrun && (pushed || dropped)))
    else $error("conflicting status flags");

  // a dropped sample means the FIFO is at its limit
  assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> fill_level == CW'(FIFO_DEPTH - 1))
    else $error("drop while FIFO not full");

  // a stored sample leaves at least one entry
  assert property (@(posedge clk) disable iff (rst)
    out_valid && pushed |-> fill_level != '0)
    else $error("push left FIFO empty");

endmodule

bind audio_decimate_filter_fifo_core adf_check #(
  .FIFO_DEPTH  (FIFO_DEPTH),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_adf_check (.*);
